[sv/acv_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the adapter container verifier.
package acv_pkg;

   localparam int TAG_BYTES      = 32;
   localparam int HEADER_BYTES   = 276;
   localparam int LEN_BITS       = 32;
   localparam int NUM_LANES      = 4;
   localparam int LANE_BYTES     = 8;
   localparam int MIN_FILE_BYTES = HEADER_BYTES + TAG_BYTES;
   localparam int FILL_BITS      = $clog2(TAG_BYTES) + 1;

   localparam int OFF_VERSION = 8;
   localparam int OFF_IN      = 240;
   localparam int OFF_OUT     = 244;
   localparam int OFF_RANK    = 248;
   localparam int OFF_ALPHA   = 252;
   localparam int OFF_SEED    = 260;

   localparam int PRIME_SHIFT    = 40;
   localparam int PRIME_LOW_BITS = 10;

   localparam logic [63:0] LANE_SEED [NUM_LANES] = '{
      64'hCBF29CE484222325, 64'h9E3779B97F4A7C15,
      64'hD1B54A32D192ED03, 64'hA3B1C2D3E4F5061F
   };
   // each prime is 2^40 plus a small low part
   localparam logic [PRIME_LOW_BITS-1:0] LANE_PRIME_LOW [NUM_LANES] = '{
      10'h1B3, 10'h1D1, 10'h1E5, 10'h20F
   };

   // status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_MAGIC   = 3'd1;
   localparam logic [2:0] ST_VERSION = 3'd2;
   localparam logic [2:0] ST_FORMAT  = 3'd3;
   localparam logic [2:0] ST_MAC     = 3'd4;

   // register indexes
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAGIC    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VERSION  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_IN   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_OUT  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_RANK = 3'd4;

   typedef logic [LEN_BITS-1:0] count_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_word_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] input_dim;
      logic signed [31:0] output_dim;
      logic signed [31:0] rank_value;
      logic [31:0]        alpha_bits;
      logic [63:0]        seed_value;
   } rsp_word_type;

   typedef struct packed {
      logic [63:0] magic;
      logic [31:0] version;
      logic [31:0] in_dim;
      logic [31:0] out_dim;
      logic [31:0] rank;
      logic [31:0] alpha;
      logic [63:0] seed;
   } capture_type;

   typedef struct packed {
      logic short_file;
      logic saturated;
      logic length_ok;
   } check_type;

   // xor in one byte, then multiply by 2^40 + low part as shifted adds
   function automatic logic [63:0] fnv_step(logic [63:0] h, logic [7:0] b,
                                            logic [PRIME_LOW_BITS-1:0] low);
      logic [63:0] x;
      logic [63:0] acc;
      x   = h ^ {56'd0, b};
      acc = x << PRIME_SHIFT;
      for (int i = 0; i < PRIME_LOW_BITS; i++) begin
         if (low[i]) begin
            acc = acc + (x << i);
         end
      end
      return acc;
   endfunction

   function automatic logic dim_ok(logic [31:0] v, logic [30:0] limit);
      return !v[31] && (v != 32'd0) && (v[30:0] <= limit);
   endfunction

   function automatic logic alpha_ok(logic [31:0] bits);
      logic nan;
      nan = (bits[30:23] == 8'hFF) && (bits[22:0] != 23'd0);
      return !bits[31] && (bits != 32'd0) && !nan;
   endfunction

endpackage

[sv/acv_capture.sv]
`timescale 1ns / 1ps
// Byte counter, header field capture and payload length check.
module acv_capture
   import acv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  data_byte,
   input  logic        last,
   output capture_type fields_in,
   output check_type   chk
);

   localparam count_type COUNT_MAX = '1;

   count_type   count_ff;
   count_type   count_in;
   count_type   total;
   capture_type fields_ff;
   logic        sat;
   logic [62:0] units_ff;
   logic [64:0] target_ff;

   function automatic logic in_win(count_type p, count_type base, count_type len);
      return (p >= base) && (p < base + len);
   endfunction

   assign sat      = (count_ff == COUNT_MAX);
   assign total    = count_ff + count_type'(1);
   assign count_in = last ? '0 : (sat ? count_ff : total);

   always_comb begin
      fields_in = fields_ff;
      if (count_ff < count_type'(8)) begin
         fields_in.magic = {data_byte, fields_ff.magic[63:8]};
      end
      if (in_win(count_ff, count_type'(OFF_VERSION), count_type'(4))) begin
         fields_in.version = {data_byte, fields_ff.version[31:8]};
      end
      if (in_win(count_ff, count_type'(OFF_IN), count_type'(4))) begin
         fields_in.in_dim = {data_byte, fields_ff.in_dim[31:8]};
      end
      if (in_win(count_ff, count_type'(OFF_OUT), count_type'(4))) begin
         fields_in.out_dim = {data_byte, fields_ff.out_dim[31:8]};
      end
      if (in_win(count_ff, count_type'(OFF_RANK), count_type'(4))) begin
         fields_in.rank = {data_byte, fields_ff.rank[31:8]};
      end
      if (in_win(count_ff, count_type'(OFF_ALPHA), count_type'(4))) begin
         fields_in.alpha = {data_byte, fields_ff.alpha[31:8]};
      end
      if (in_win(count_ff, count_type'(OFF_SEED), count_type'(8))) begin
         fields_in.seed = {data_byte, fields_ff.seed[63:8]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         fields_ff <= '0;
      end else if (step) begin
         count_ff  <= count_in;
         fields_ff <= last ? '0 : fields_in;
      end
   end

   // Dims settle at offset 251; the file end is at least 56 bytes later,
   // so two stages of lag on the expected length are harmless.
   always_ff @(posedge clock) begin
      units_ff  <= 63'(fields_ff.rank[30:0]) *
                   63'({1'b0, fields_ff.in_dim[30:0]} + {1'b0, fields_ff.out_dim[30:0]});
      target_ff <= {units_ff, 2'b00} + 65'(MIN_FILE_BYTES);
   end

   assign chk.short_file = !sat && (count_ff < count_type'(MIN_FILE_BYTES - 1));
   assign chk.saturated  = sat;
   assign chk.length_ok  = (65'(total) == target_ff);

endmodule

[sv/acv_tagcheck.sv]
`timescale 1ns / 1ps
// Tag delay line, four hash lanes and the final tag compare.
module acv_tagcheck
   import acv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       last,
   output logic       tag_match
);

   logic [7:0]           delay_ff [TAG_BYTES];
   logic [7:0]           delay_in [TAG_BYTES];
   logic [63:0]          lane_ff  [NUM_LANES];
   logic [63:0]          lane_in  [NUM_LANES];
   logic [FILL_BITS-1:0] fill_ff;
   logic                 absorb;

   // lanes take the byte leaving the delay line once it is full
   assign absorb = fill_ff[FILL_BITS-1];

   always_comb begin
      for (int i = 0; i < TAG_BYTES - 1; i++) begin
         delay_in[i] = delay_ff[i+1];
      end
      delay_in[TAG_BYTES-1] = data_byte;
      for (int k = 0; k < NUM_LANES; k++) begin
         lane_in[k] = absorb ? fnv_step(lane_ff[k], delay_ff[0], LANE_PRIME_LOW[k])
                             : lane_ff[k];
      end
   end

   always_comb begin
      tag_match = 1'b1;
      for (int k = 0; k < NUM_LANES; k++) begin
         for (int i = 0; i < LANE_BYTES; i++) begin
            if (delay_in[k*LANE_BYTES + i] != lane_in[k][8*i +: 8]) begin
               tag_match = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         fill_ff <= '0;
         for (int i = 0; i < TAG_BYTES; i++) begin
            delay_ff[i] <= 8'd0;
         end
         for (int k = 0; k < NUM_LANES; k++) begin
            lane_ff[k] <= LANE_SEED[k];
         end
      end else if (step) begin
         if (!absorb) begin
            fill_ff <= fill_ff + FILL_BITS'(1);
         end
         for (int i = 0; i < TAG_BYTES; i++) begin
            delay_ff[i] <= delay_in[i];
         end
         for (int k = 0; k < NUM_LANES; k++) begin
            lane_ff[k] <= lane_in[k];
         end
      end
   end

endmodule

[sv/adapter_container_verifier_top.sv]
`timescale 1ns / 1ps
// The status word is registered when the last byte advances out of the input register.
// Throughput: one byte per cycle, set by the per-byte xor-multiply loop of the hash lanes.
// A last byte waits in the input register only while an earlier status word is stalled.
// Reset (synchronous, active high) loads the lanes with their seeds, clears the delay
// line, byte count and captured fields, and returns the registers to their defaults.
module adapter_container_verifier_top
   import acv_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_word_type              req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_word_type              rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [63:0]               csr_wdata
);

   logic [63:0]  exp_magic_ff;
   logic [31:0]  exp_version_ff;
   logic [30:0]  max_in_ff;
   logic [30:0]  max_out_ff;
   logic [30:0]  max_rank_ff;

   logic         in_valid_ff;
   req_word_type in_ff;
   logic         advance;
   logic         accept;

   rsp_word_type rsp_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic [2:0]   status;

   capture_type  fields;
   check_type    chk;
   logic         tag_match;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_magic_ff   <= 64'd0;
         exp_version_ff <= 32'd1;
         max_in_ff      <= 31'd4096;
         max_out_ff     <= 31'd4096;
         max_rank_ff    <= 31'd64;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAGIC:    exp_magic_ff   <= csr_wdata;
            CSR_VERSION:  exp_version_ff <= csr_wdata[31:0];
            CSR_MAX_IN:   max_in_ff      <= csr_wdata[30:0];
            CSR_MAX_OUT:  max_out_ff     <= csr_wdata[30:0];
            CSR_MAX_RANK: max_rank_ff    <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // hold a last byte while the previous status word is stalled
   assign advance   = in_valid_ff && !(in_ff.last && rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
      end
   end

   acv_capture u_capture (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_ff.data_byte),
      .last      (in_ff.last),
      .fields_in (fields),
      .chk       (chk)
   );

   acv_tagcheck u_tagcheck (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_ff.data_byte),
      .last      (in_ff.last),
      .tag_match (tag_match)
   );

   always_comb begin
      priority if (chk.short_file) begin
         status = ST_FORMAT;
      end else if (fields.magic != exp_magic_ff) begin
         status = ST_MAGIC;
      end else if (fields.version != exp_version_ff) begin
         status = ST_VERSION;
      end else if (!dim_ok(fields.in_dim, max_in_ff) ||
                   !dim_ok(fields.out_dim, max_out_ff) ||
                   !dim_ok(fields.rank, max_rank_ff) ||
                   !alpha_ok(fields.alpha) ||
                   chk.saturated || !chk.length_ok) begin
         status = ST_FORMAT;
      end else if (!tag_match) begin
         status = ST_MAC;
      end else begin
         status = ST_OK;
      end
   end

   assign rsp_valid_in = (advance && in_ff.last) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_ff.last) begin
         rsp_ff.status     <= status;
         rsp_ff.input_dim  <= fields.in_dim;
         rsp_ff.output_dim <= fields.out_dim;
         rsp_ff.rank_value <= fields.rank;
         rsp_ff.alpha_bits <= fields.alpha;
         rsp_ff.seed_value <= fields.seed;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[sv/acv_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the verifier top level, with its bind statement.
module acv_checker
   import acv_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("status word changed while stalled");

   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with no status word pending");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_MAC)
      else $error("status code out of range");

   a_ok_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_OK) |->
         (rsp_data.input_dim > 0) && (rsp_data.output_dim > 0) &&
         (rsp_data.rank_value > 0) && !rsp_data.alpha_bits[31])
      else $error("ok status with header fields that should fail");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("status word valid right after reset");

endmodule

bind adapter_container_verifier_top acv_checker u_acv_checker (.*);

[tb/tb_adapter_container_verifier_top.sv]
`timescale 1ns / 1ps
// Testbench for the adapter container verifier: streams container files and checks each status word.
module tb_adapter_container_verifier_top;
   import acv_pkg::*;

   localparam logic [63:0] LANE_MULT [NUM_LANES] = '{
      64'h00000100000001B3, 64'h00000100000001D1,
      64'h00000100000001E5, 64'h000001000000020F
   };
   localparam longint unsigned COUNT_LIMIT = (64'd1 << LEN_BITS) - 1;
   localparam int DRAIN_CYCLES = 6;

   localparam logic [31:0] ALPHA_ONE = 32'h3F800000;
   localparam logic [31:0] ALPHA_INF = 32'h7F800000;
   localparam logic [31:0] ALPHA_NAN = 32'h7FC00000;
   localparam logic [31:0] ALPHA_NEG = 32'hBF800000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_word_type              req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_word_type              rsp_data;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_MAGIC;
   logic [63:0]               csr_wdata = '0;

   adapter_container_verifier_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // register copies
   logic [63:0] cfg_magic;
   logic [31:0] cfg_version;
   logic [30:0] cfg_max_in;
   logic [30:0] cfg_max_out;
   logic [30:0] cfg_max_rank;

   // per-file state of the verifier
   logic [63:0]     hash_lane [NUM_LANES];
   logic [7:0]      tail_buf [TAG_BYTES];
   longint unsigned bytes_seen;
   logic [63:0]     magic_cap;
   logic [31:0]     ver_cap;
   logic [31:0]     in_cap;
   logic [31:0]     out_cap;
   logic [31:0]     rank_cap;
   logic [31:0]     alpha_cap;
   logic [63:0]     seed_cap;

   rsp_word_type verdict_q [$];
   logic [7:0]   file_buf [$];

   int error_count   = 0;
   int files_sent    = 0;
   int bytes_sent    = 0;
   int verdicts_seen = 0;
   int csr_writes    = 0;
   int hold_request  = 0;
   int hold_left     = 0;
   bit req_gaps_on   = 1'b1;
   bit rsp_gaps_on   = 1'b1;

   function automatic logic [63:0] lane_mix(logic [63:0] h, logic [7:0] b, int k);
      return (h ^ {56'd0, b}) * LANE_MULT[k];
   endfunction

   function automatic bit dim_in_range(logic [31:0] v, logic [30:0] lim);
      return $signed(v) > 0 && v <= {1'b0, lim};
   endfunction

   function automatic bit alpha_valid(logic [31:0] bits);
      bit is_nan;
      is_nan = (&bits[30:23]) && (|bits[22:0]);
      return !bits[31] && (bits[30:0] != 31'd0) && !is_nan;
   endfunction

   task automatic clear_file_state();
      for (int k = 0; k < NUM_LANES; k++) hash_lane[k] = LANE_SEED[k];
      for (int i = 0; i < TAG_BYTES; i++) tail_buf[i] = 8'd0;
      bytes_seen = 0;
      magic_cap  = '0;
      ver_cap    = '0;
      in_cap     = '0;
      out_cap    = '0;
      rank_cap   = '0;
      alpha_cap  = '0;
      seed_cap   = '0;
   endtask

   function automatic logic [2:0] file_status(longint unsigned total, bit sat);
      longint unsigned diff;
      longint unsigned units;
      if (total < MIN_FILE_BYTES) return ST_FORMAT;
      if (magic_cap != cfg_magic) return ST_MAGIC;
      if (ver_cap != cfg_version) return ST_VERSION;
      if (!dim_in_range(in_cap, cfg_max_in) || !dim_in_range(out_cap, cfg_max_out) ||
          !dim_in_range(rank_cap, cfg_max_rank) || !alpha_valid(alpha_cap))
         return ST_FORMAT;
      if (sat) return ST_FORMAT;
      diff  = total - MIN_FILE_BYTES;
      units = 64'(rank_cap) * (64'(in_cap) + 64'(out_cap));
      if (diff[1:0] != 2'd0 || (diff >> 2) != units) return ST_FORMAT;
      for (int k = 0; k < NUM_LANES; k++)
         for (int i = 0; i < LANE_BYTES; i++)
            if (tail_buf[k*LANE_BYTES + i] != hash_lane[k][8*i +: 8]) return ST_MAC;
      return ST_OK;
   endfunction

   // advance the file state by one accepted word; queue a status word on the last byte
   task automatic absorb_byte(logic [7:0] b, logic is_last);
      longint unsigned pos;
      bit              sat;
      rsp_word_type    w;
      pos = bytes_seen;
      if (pos < 8) magic_cap = {b, magic_cap[63:8]};
      if (pos >= OFF_VERSION && pos < OFF_VERSION + 4) ver_cap = {b, ver_cap[31:8]};
      if (pos >= OFF_IN && pos < OFF_IN + 4) in_cap = {b, in_cap[31:8]};
      if (pos >= OFF_OUT && pos < OFF_OUT + 4) out_cap = {b, out_cap[31:8]};
      if (pos >= OFF_RANK && pos < OFF_RANK + 4) rank_cap = {b, rank_cap[31:8]};
      if (pos >= OFF_ALPHA && pos < OFF_ALPHA + 4) alpha_cap = {b, alpha_cap[31:8]};
      if (pos >= OFF_SEED && pos < OFF_SEED + 8) seed_cap = {b, seed_cap[63:8]};
      if (pos >= TAG_BYTES)
         for (int k = 0; k < NUM_LANES; k++) hash_lane[k] = lane_mix(hash_lane[k], tail_buf[0], k);
      for (int i = 0; i < TAG_BYTES - 1; i++) tail_buf[i] = tail_buf[i+1];
      tail_buf[TAG_BYTES-1] = b;
      sat = (pos >= COUNT_LIMIT);
      if (!sat) bytes_seen = pos + 1;
      if (is_last) begin
         w.status     = file_status(sat ? COUNT_LIMIT : pos + 1, sat);
         w.input_dim  = in_cap;
         w.output_dim = out_cap;
         w.rank_value = rank_cap;
         w.alpha_bits = alpha_cap;
         w.seed_value = seed_cap;
         verdict_q.push_back(w);
         clear_file_state();
      end
   endtask

   task automatic send_word(logic [7:0] b, logic is_last);
      if (req_gaps_on) begin
         while ($urandom_range(99) < 25) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, last: is_last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      absorb_byte(b, is_last);
      bytes_sent++;
   endtask

   task automatic send_file();
      for (int i = 0; i < file_buf.size(); i++) send_word(file_buf[i], i == file_buf.size() - 1);
      files_sent++;
   endtask

   // hold off the sender until every status word is back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [63:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_MAGIC:    cfg_magic    = value;
         CSR_VERSION:  cfg_version  = value[31:0];
         CSR_MAX_IN:   cfg_max_in   = value[30:0];
         CSR_MAX_OUT:  cfg_max_out  = value[30:0];
         CSR_MAX_RANK: cfg_max_rank = value[30:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   // header with random filler, payload, tag over all before it; tag_good clear flips a tag bit
   task automatic build_file(logic [63:0] m, logic [31:0] v, logic [31:0] in_d,
                             logic [31:0] out_d, logic [31:0] rank_d, logic [31:0] alpha,
                             int plen, bit tag_good);
      logic [63:0] h [NUM_LANES];
      logic [63:0] seed;
      int          j;
      seed = {$urandom, $urandom};
      file_buf.delete();
      for (int i = 0; i < HEADER_BYTES; i++) file_buf.push_back(8'($urandom));
      for (int i = 0; i < 8; i++) begin
         file_buf[i]            = m[8*i +: 8];
         file_buf[OFF_SEED + i] = seed[8*i +: 8];
      end
      for (int i = 0; i < 4; i++) begin
         file_buf[OFF_VERSION + i] = v[8*i +: 8];
         file_buf[OFF_IN + i]      = in_d[8*i +: 8];
         file_buf[OFF_OUT + i]     = out_d[8*i +: 8];
         file_buf[OFF_RANK + i]    = rank_d[8*i +: 8];
         file_buf[OFF_ALPHA + i]   = alpha[8*i +: 8];
      end
      for (int i = 0; i < plen; i++) file_buf.push_back(8'($urandom));
      for (int k = 0; k < NUM_LANES; k++) begin
         h[k] = LANE_SEED[k];
         foreach (file_buf[i]) h[k] = lane_mix(h[k], file_buf[i], k);
      end
      for (int k = 0; k < NUM_LANES; k++)
         for (int i = 0; i < LANE_BYTES; i++) file_buf.push_back(h[k][8*i +: 8]);
      if (!tag_good) begin
         j = file_buf.size() - 1 - $urandom_range(0, TAG_BYTES - 1);
         file_buf[j] ^= 8'h01 << $urandom_range(0, 7);
      end
   endtask

   task automatic send_case(logic [63:0] m, logic [31:0] v, logic [31:0] in_d,
                            logic [31:0] out_d, logic [31:0] rank_d, logic [31:0] alpha,
                            int plen, bit tag_good);
      build_file(m, v, in_d, out_d, rank_d, alpha, plen, tag_good);
      send_file();
   endtask

   task automatic send_noise(int n);
      file_buf.delete();
      for (int i = 0; i < n; i++) file_buf.push_back(8'($urandom));
      send_file();
   endtask

   function automatic logic [31:0] pick_dim(logic [30:0] lim, int top);
      return $urandom_range(1, (lim < top) ? lim : top);
   endfunction

   function automatic logic [63:0] pick_limit();
      if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
      return $urandom_range(1, 8);
   endfunction

   task automatic test_status_codes();
      send_case(cfg_magic, cfg_version, 1, 1, 1, ALPHA_ONE, 8, 1);
      send_case(cfg_magic, cfg_version, 3, 2, 4, ALPHA_INF, 80, 1);
      send_case(cfg_magic, cfg_version, 4096, 1, 1, ALPHA_ONE, 16388, 1);
      send_case(cfg_magic, cfg_version, 1, 4096, 1, ALPHA_ONE, 16388, 1);
      send_case(cfg_magic, cfg_version, 1, 1, 64, ALPHA_ONE, 512, 1);
      send_case(cfg_magic ^ 64'h1, cfg_version, 1, 1, 1, ALPHA_ONE, 8, 1);
      send_case(cfg_magic, cfg_version + 1, 1, 1, 1, ALPHA_ONE, 8, 1);
      send_case(cfg_magic ^ 64'h1, cfg_version + 1, 1, 1, 1, ALPHA_ONE, 8, 1);
      send_case(cfg_magic, cfg_version, 0, 1, 1, ALPHA_ONE, 4, 1);
      send_case(cfg_magic, cfg_version, 1, 32'hFFFFFFFF, 1, ALPHA_ONE, 8, 1);
      send_case(cfg_magic, cfg_version, 1, 1, 65, ALPHA_ONE, 520, 1);
      send_case(cfg_magic, cfg_version, 4097, 1, 1, ALPHA_ONE, 16392, 1);
      send_case(cfg_magic, cfg_version, 1, 1, 1, 32'd0, 8, 1);
      send_case(cfg_magic, cfg_version, 1, 1, 1, ALPHA_NAN, 8, 1);
      send_case(cfg_magic, cfg_version, 1, 1, 1, ALPHA_NEG, 8, 1);
      // payload length: not a multiple of four, wrong count, none at all; then a bad tag
      send_case(cfg_magic, cfg_version, 1, 1, 1, ALPHA_ONE, 9, 1);
      send_case(cfg_magic, cfg_version, 1, 1, 1, ALPHA_ONE, 12, 1);
      send_case(cfg_magic, cfg_version, 1, 1, 1, ALPHA_ONE, 0, 1);
      send_case(cfg_magic, cfg_version, 2, 3, 2, ALPHA_ONE, 40, 0);
      // files too short, ending inside the magic, inside a dimension, one byte early
      send_noise(1);
      send_noise(6);
      send_noise(242);
      send_noise(MIN_FILE_BYTES - 1);
   endtask

   task automatic test_register_writes();
      wait_idle();
      // bits above each register's width must be dropped
      write_reg(CSR_MAGIC, '1);
      write_reg(CSR_VERSION, '1);
      write_reg(CSR_MAX_IN, '1);
      write_reg(CSR_MAX_OUT, '1);
      write_reg(CSR_MAX_RANK, '1);
      for (int i = CSR_MAX_RANK + 1; i < (1 << CSR_INDEX_BITS); i++)
         write_reg(CSR_INDEX_BITS'(i), {$urandom, $urandom});
      send_case(cfg_magic, cfg_version, 2, 1, 3, ALPHA_INF, 36, 1);
      send_case(cfg_magic, cfg_version, 32'h7FFFFFFF, 1, 1, ALPHA_ONE, 8, 1);
      send_case(cfg_magic, cfg_version, 1, 32'h7FFFFFFF, 32'h7FFFFFFF, ALPHA_ONE, 8, 1);
      send_case(cfg_magic, cfg_version, 32'h80000000, 1, 1, ALPHA_ONE, 8, 1);
      send_case(cfg_magic, cfg_version, 1, 1, 1, ALPHA_ONE, 8, 0);
      wait_idle();
      write_reg(CSR_MAGIC, {$urandom, $urandom});
      write_reg(CSR_VERSION, 64'hFFFFFFFF_00000000);
      write_reg(CSR_MAX_IN, 64'h80000001);
      write_reg(CSR_MAX_OUT, 64'h80000001);
      write_reg(CSR_MAX_RANK, 64'h80000001);
      send_case(cfg_magic, cfg_version, 1, 1, 1, ALPHA_ONE, 8, 1);
      send_case(cfg_magic, cfg_version, 2, 1, 1, ALPHA_ONE, 12, 1);
      send_case(cfg_magic, cfg_version, 1, 2, 1, ALPHA_ONE, 12, 1);
      send_case(cfg_magic, cfg_version, 1, 1, 2, ALPHA_ONE, 16, 1);
      wait_idle();
      // a zero limit rejects every dimension
      write_reg(CSR_MAX_IN, 64'd0);
      send_case(cfg_magic, cfg_version, 1, 1, 1, ALPHA_ONE, 8, 1);
      wait_idle();
      write_reg(CSR_MAX_IN, 64'd16);
      write_reg(CSR_MAX_OUT, 64'd0);
      send_case(cfg_magic, cfg_version, 1, 1, 1, ALPHA_ONE, 8, 1);
      wait_idle();
      write_reg(CSR_MAX_OUT, 64'd16);
      write_reg(CSR_MAX_RANK, 64'd0);
      send_case(cfg_magic, cfg_version, 1, 1, 1, ALPHA_ONE, 8, 1);
      wait_idle();
      write_reg(CSR_MAX_RANK, 64'd4);
   endtask

   task automatic test_backpressure();
      wait_idle();
      hold_request = 300;
      for (int n = 0; n < 12; n++) send_noise($urandom_range(1, 3));
      send_case(cfg_magic, cfg_version, 1, 2, 1, ALPHA_ONE, 12, 1);
      wait_idle();
   endtask

   task automatic test_random_files();
      logic [31:0] in_d;
      logic [31:0] out_d;
      logic [31:0] rank_d;
      logic [31:0] alpha;
      int          plen;
      int          kind;
      int          cut;
      for (int phase = 0; phase < 4; phase++) begin
         wait_idle();
         write_reg(CSR_MAGIC, {$urandom, $urandom});
         write_reg(CSR_VERSION, {$urandom, $urandom});
         write_reg(CSR_MAX_IN, pick_limit());
         write_reg(CSR_MAX_OUT, pick_limit());
         write_reg(CSR_MAX_RANK, pick_limit());
         req_gaps_on = (phase != 2);
         rsp_gaps_on = (phase != 2);
         for (int n = 0; n < 15; n++) begin
            in_d   = pick_dim(cfg_max_in, 6);
            out_d  = pick_dim(cfg_max_out, 6);
            rank_d = pick_dim(cfg_max_rank, 4);
            alpha  = {1'b0, 8'($urandom_range(1, 254)), 23'($urandom)};
            plen   = 4 * rank_d * (in_d + out_d);
            kind   = $urandom_range(0, 19);
            build_file(cfg_magic, cfg_version, in_d, out_d, rank_d, alpha, plen, kind != 5);
            case (kind)
               0: file_buf[$urandom_range(0, 7)] ^= 8'h01 << $urandom_range(0, 7);
               1: file_buf[OFF_VERSION + $urandom_range(0, 3)] ^= 8'h01 << $urandom_range(0, 7);
               2: file_buf[OFF_IN + $urandom_range(0, 11)] = 8'($urandom);
               3: file_buf[OFF_ALPHA + $urandom_range(0, 3)] = 8'($urandom);
               4: build_file(cfg_magic, cfg_version, in_d, out_d, rank_d, alpha,
                             plen + $urandom_range(1, 8), 1);
               6: begin
                  cut = $urandom_range(1, file_buf.size() - 1);
                  file_buf = file_buf[0:cut-1];
               end
               7: begin
                  file_buf.delete();
                  repeat ($urandom_range(1, 40)) file_buf.push_back(8'($urandom));
               end
               default: ;
            endcase
            send_file();
         end
      end
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   // receiver: random stalls, or a long hold when asked
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= rsp_gaps_on && ($urandom_range(99) < 25);
      end
   end

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : check_words
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         verdicts_seen++;
         if (verdict_q.size() == 0) begin
            $error("status word %0d with no file pending", rsp_data.status);
            error_count++;
         end else begin
            want = verdict_q.pop_front();
            check_field("status", want.status, rsp_data.status);
            check_field("input_dim", want.input_dim, rsp_data.input_dim);
            check_field("output_dim", want.output_dim, rsp_data.output_dim);
            check_field("rank_value", want.rank_value, rsp_data.rank_value);
            check_field("alpha_bits", want.alpha_bits, rsp_data.alpha_bits);
            check_field("seed_value", want.seed_value, rsp_data.seed_value);
         end
      end
   end

   initial begin
      #(8_000_000);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      cfg_magic    = '0;
      cfg_version  = 32'd1;
      cfg_max_in   = 31'd4096;
      cfg_max_out  = 31'd4096;
      cfg_max_rank = 31'd64;
      clear_file_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_status_codes();
      test_register_writes();
      test_backpressure();
      test_random_files();
      wait_idle();
      repeat (10) @(posedge clock);
      $display("Streamed %0d files (%0d bytes), checked %0d status words", files_sent,
               bytes_sent, verdicts_seen);
      $display("Register writes: %0d, covering limit extremes, zero limits and unused indexes",
               csr_writes);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
